// ----- sv/anfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anfs_pkg
// Shared widths, reset values and codes for the animation frame stepper.
// ----------------------------------------------------------------------------
package anfs_pkg;

  localparam int TIME_BITS  = 32;                      // frame_time, anim_time, delta
  localparam int FRAME_BITS = 16;                      // frame numbers and counts
  localparam int PLAY_BITS  = TIME_BITS + 8;           // play-time accumulator
  localparam int PROD_BITS  = TIME_BITS + FRAME_BITS;  // frame_time * frame
  localparam int FRAC_BITS  = 17;                      // Q0.16 plus the integer one
  localparam int QFRAC_BITS = FRAC_BITS - 1;           // quotient bits of the fraction
  localparam int CNT_BITS   = $clog2(PLAY_BITS + 1);
  localparam int FUNC_BITS  = 2;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  localparam logic [FRAC_BITS-1:0]  ONE_Q16   = FRAC_BITS'(65536);
  localparam logic [PLAY_BITS-1:0]  PLAY_MAX  = '1;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  localparam logic [TIME_BITS-1:0]  FRAME_TIME_RST  = TIME_BITS'(33333);
  localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RST = FRAME_BITS'(1);
  localparam logic [TIME_BITS-1:0]  ANIM_TIME_RST   = TIME_BITS'(33333);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_PLAY = 2'd1,
    FUNC_STOP = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_FRAME_TIME  = 2'd0,
    REG_FRAME_COUNT = 2'd1,
    REG_ANIM_TIME   = 2'd2,
    REG_REPEAT_ON   = 2'd3
  } reg_idx_e;

endpackage

// ----- sv/animation_frame_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_frame_stepper
// Keyframe animation timer: play-time accumulator, frame stepping and a
// Q0.16 interpolation fraction, worked out with bit-serial multiply/divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func_i and delta_us_i:
//   tick (adds delta_us_i while playing), play or stop. Every transaction
//   yields exactly one result transaction on the output channel
//   (out_valid_o / out_stall_i): frame_index_o, fetch_frame_o,
//   interp_frac_o, playing_o.
//   States from accept to the output register, by transaction (S_DONE last):
//     play, stop, other codes, tick while stopped : S_DONE only
//     tick reaching the end with repeat off : S_ADD, S_CHK
//     tick within a frame : S_ADD, S_CHK, 16-step serial multiply for
//       frame_time * frame (S_MUL), S_CMP, S_FRAC, 16-step restoring divide
//       for the fraction (S_DIV), S_FIN; no divide if it saturates to 0 or 1
//     tick longer than a frame : S_ADD, S_CHK, 40-step restoring divide
//       (S_DIV) of the play time by frame_time, S_FIN
//   One transaction is in work at a time; in_stall_o is high while busy, so
//   the next is taken only once the result is registered and the core is idle.
//   A new transaction is taken while the previous result still waits in the
//   output register; a finished result then holds in the core until it frees.
//   Reset (rst_ni low, asynchronous): play time 0, frame 1, stopped, fraction 0
//   and register defaults. The user must write registers (APB, byte address
//   4*index) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module animation_frame_stepper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [anfs_pkg::FUNC_BITS-1:0]   func_i,
  input  logic [anfs_pkg::TIME_BITS-1:0]   delta_us_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [anfs_pkg::FRAME_BITS-1:0]  frame_index_o,
  output logic [anfs_pkg::FRAME_BITS-1:0]  fetch_frame_o,
  output logic [anfs_pkg::FRAC_BITS-1:0]   interp_frac_o,
  output logic                             playing_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [anfs_pkg::APB_AW-1:0]      paddr,
  input  logic [anfs_pkg::APB_DW-1:0]      pwdata,
  output logic [anfs_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import anfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,    // saturating accumulate
    S_CHK,    // end of animation / branch on tick length
    S_MUL,    // serial frame_time * cur_frame
    S_CMP,    // compare play time with frame boundary, step frame
    S_FRAC,   // saturate fraction or set up its divide
    S_DIV,    // restoring divide, one quotient bit a cycle
    S_FIN,    // write back quotient
    S_DONE    // result waits for output register
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [TIME_BITS-1:0]  frame_time_q, frame_time_d;
  logic [FRAME_BITS-1:0] frame_count_q, frame_count_d;
  logic [TIME_BITS-1:0]  anim_time_q, anim_time_d;
  logic                  repeat_on_q, repeat_on_d;

  // animation state
  logic [PLAY_BITS-1:0]  play_time_q, play_time_d;
  logic [FRAME_BITS-1:0] cur_frame_q, cur_frame_d;
  logic                  is_playing_q, is_playing_d;
  logic [FRAC_BITS-1:0]  last_frac_q, last_frac_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] frame_index_q, frame_index_d;
  logic [FRAME_BITS-1:0] fetch_frame_q, fetch_frame_d;
  logic [FRAC_BITS-1:0]  interp_frac_q, interp_frac_d;
  logic                  playing_q, playing_d;

  // serial datapath
  logic [TIME_BITS-1:0]  delta_q, delta_d;
  logic [PROD_BITS-1:0]  acc_q, acc_d;     // product accumulator
  logic [FRAME_BITS-1:0] mul_q, mul_d;     // multiplier bits, MSB first
  logic [PROD_BITS-1:0]  mag_q, mag_d;     // |play_time - next|
  logic                  ge_q, ge_d;       // play_time >= next
  logic [TIME_BITS-1:0]  rem_q, rem_d;     // divider remainder
  logic [PLAY_BITS-1:0]  dvd_q, dvd_d;     // dividend in, quotient out
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  plus1_q, plus1_d;
  logic                  frame_div_q, frame_div_d;

  // combinational helpers
  logic                  in_acc;
  logic                  cfg_wr;
  logic [TIME_BITS-1:0]  ft;
  logic [PLAY_BITS:0]    add_sum;
  logic [PROD_BITS:0]    pt_minus_next;
  logic [PROD_BITS-1:0]  next_minus_pt;
  logic [FRAME_BITS:0]   next_frame;
  logic [TIME_BITS:0]    div_shift;
  logic                  div_ge;
  logic [PLAY_BITS:0]    q_sum;
  logic [PLAY_BITS-1:0]  pt_less_anim;
  logic [FRAME_BITS-1:0] fetch_calc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign ft     = (frame_time_q == '0) ? TIME_BITS'(1) : frame_time_q;

  assign add_sum       = {1'b0, play_time_q} + (PLAY_BITS + 1)'(delta_q);
  assign pt_minus_next = {1'b0, PROD_BITS'(play_time_q)} - {1'b0, acc_q};
  assign next_minus_pt = acc_q - PROD_BITS'(play_time_q);
  assign next_frame    = {1'b0, cur_frame_q} + (FRAME_BITS + 1)'(1);
  assign div_shift     = {rem_q, dvd_q[PLAY_BITS-1]};
  assign div_ge        = div_shift >= {1'b0, ft};
  assign q_sum         = {1'b0, dvd_q} + (PLAY_BITS + 1)'(plus1_q);
  assign pt_less_anim  = play_time_q - PLAY_BITS'(anim_time_q);
  assign fetch_calc    = (cur_frame_q != '0 && cur_frame_q == frame_count_q) ?
                         cur_frame_q - FRAME_BITS'(1) : cur_frame_q;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign frame_index_o = frame_index_q;
  assign fetch_frame_o = fetch_frame_q;
  assign interp_frac_o = interp_frac_q;
  assign playing_o     = playing_q;
  assign pready        = 1'b1;

  // register read-back
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_FRAME_TIME:  prdata = APB_DW'(frame_time_q);
      REG_FRAME_COUNT: prdata = APB_DW'(frame_count_q);
      REG_ANIM_TIME:   prdata = APB_DW'(anim_time_q);
      REG_REPEAT_ON:   prdata = APB_DW'(repeat_on_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    frame_time_d  = frame_time_q;
    frame_count_d = frame_count_q;
    anim_time_d   = anim_time_q;
    repeat_on_d   = repeat_on_q;
    play_time_d   = play_time_q;
    cur_frame_d   = cur_frame_q;
    is_playing_d  = is_playing_q;
    last_frac_d   = last_frac_q;
    out_valid_d   = out_valid_q;
    frame_index_d = frame_index_q;
    fetch_frame_d = fetch_frame_q;
    interp_frac_d = interp_frac_q;
    playing_d     = playing_q;
    delta_d       = delta_q;
    acc_d         = acc_q;
    mul_d         = mul_q;
    mag_d         = mag_q;
    ge_d          = ge_q;
    rem_d         = rem_q;
    dvd_d         = dvd_q;
    cnt_d         = cnt_q;
    plus1_d       = plus1_q;
    frame_div_d   = frame_div_q;

    if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_FRAME_TIME:  frame_time_d  = pwdata[TIME_BITS-1:0];
        REG_FRAME_COUNT: frame_count_d = pwdata[FRAME_BITS-1:0];
        REG_ANIM_TIME:   anim_time_d   = pwdata[TIME_BITS-1:0];
        REG_REPEAT_ON:   repeat_on_d   = pwdata[0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          delta_d = delta_us_i;
          state_d = S_DONE;
          case (func_e'(func_i))
            FUNC_TICK: if (is_playing_q) state_d = S_ADD;
            FUNC_PLAY: begin
              if (!is_playing_q) begin
                // restart after the end rewinds to frame 1
                if (play_time_q >= PLAY_BITS'(anim_time_q)) begin
                  play_time_d = '0;
                  cur_frame_d = FRAME_BITS'(1);
                end
                is_playing_d = 1'b1;
              end
            end
            FUNC_STOP: is_playing_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_ADD: begin
        play_time_d = add_sum[PLAY_BITS] ? PLAY_MAX : add_sum[PLAY_BITS-1:0];
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (play_time_q >= PLAY_BITS'(anim_time_q) && !repeat_on_q) begin
          // park on the last frame, fraction left as it was
          cur_frame_d  = frame_count_q;
          play_time_d  = PLAY_BITS'(anim_time_q) + PLAY_BITS'(1);
          is_playing_d = 1'b0;
          state_d      = S_DONE;
        end else if (ft >= delta_q) begin
          acc_d   = '0;
          mul_d   = cur_frame_q;
          cnt_d   = CNT_BITS'(FRAME_BITS);
          state_d = S_MUL;
        end else begin
          last_frac_d = '0;
          rem_d       = '0;
          cnt_d       = CNT_BITS'(PLAY_BITS);
          frame_div_d = 1'b1;
          if (play_time_q > PLAY_BITS'(anim_time_q)) begin
            play_time_d = pt_less_anim;
            dvd_d       = pt_less_anim;
            plus1_d     = 1'b1;
          end else begin
            dvd_d       = play_time_q;
            plus1_d     = 1'b0;
          end
          state_d = S_DIV;
        end
      end
      S_MUL: begin
        // product stays below 2^PROD_BITS, far under the 2^62 cap
        acc_d = {acc_q[PROD_BITS-2:0], 1'b0} +
                (mul_q[FRAME_BITS-1] ? PROD_BITS'(ft) : '0);
        mul_d = {mul_q[FRAME_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) state_d = S_CMP;
      end
      S_CMP: begin
        ge_d = !pt_minus_next[PROD_BITS];
        mag_d = ge_d ? pt_minus_next[PROD_BITS-1:0] : next_minus_pt;
        if (ge_d) begin
          if (next_frame > {1'b0, frame_count_q}) begin
            cur_frame_d = FRAME_BITS'(1);
            play_time_d = pt_minus_next[PLAY_BITS-1:0];
          end else begin
            cur_frame_d = next_frame[FRAME_BITS-1:0];
          end
        end
        state_d = S_FRAC;
      end
      S_FRAC: begin
        // past boundary: numerator is the overshoot; before it: ft - shortfall
        rem_d       = ge_q ? mag_q[TIME_BITS-1:0] : ft - mag_q[TIME_BITS-1:0];
        dvd_d       = '0;
        cnt_d       = CNT_BITS'(QFRAC_BITS);
        frame_div_d = 1'b0;
        if (mag_q >= PROD_BITS'(ft)) begin
          last_frac_d = ge_q ? ONE_Q16 : '0;
          state_d     = S_DONE;
        end else begin
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = div_ge ? TIME_BITS'(div_shift - {1'b0, ft}) : div_shift[TIME_BITS-1:0];
        dvd_d = {dvd_q[PLAY_BITS-2:0], div_ge};
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(1)) state_d = S_FIN;
      end
      S_FIN: begin
        if (frame_div_q) begin
          cur_frame_d = (q_sum > (PLAY_BITS + 1)'(FRAME_MAX)) ?
                        FRAME_MAX : q_sum[FRAME_BITS-1:0];
        end else begin
          last_frac_d = {1'b0, dvd_q[QFRAC_BITS-1:0]};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          frame_index_d = cur_frame_q;
          fetch_frame_d = fetch_calc;
          interp_frac_d = last_frac_q;
          playing_d     = is_playing_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state, architectural registers and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      frame_time_q  <= FRAME_TIME_RST;
      frame_count_q <= FRAME_COUNT_RST;
      anim_time_q   <= ANIM_TIME_RST;
      repeat_on_q   <= 1'b0;
      play_time_q   <= '0;
      cur_frame_q   <= FRAME_BITS'(1);
      is_playing_q  <= 1'b0;
      last_frac_q   <= '0;
      out_valid_q   <= 1'b0;
      frame_index_q <= '0;
      fetch_frame_q <= '0;
      interp_frac_q <= '0;
      playing_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_time_q  <= frame_time_d;
      frame_count_q <= frame_count_d;
      anim_time_q   <= anim_time_d;
      repeat_on_q   <= repeat_on_d;
      play_time_q   <= play_time_d;
      cur_frame_q   <= cur_frame_d;
      is_playing_q  <= is_playing_d;
      last_frac_q   <= last_frac_d;
      out_valid_q   <= out_valid_d;
      frame_index_q <= frame_index_d;
      fetch_frame_q <= fetch_frame_d;
      interp_frac_q <= interp_frac_d;
      playing_q     <= playing_d;
    end
  end

  // serial datapath, no reset needed
  always_ff @(posedge clk_i) begin
    delta_q     <= delta_d;
    acc_q       <= acc_d;
    mul_q       <= mul_d;
    mag_q       <= mag_d;
    ge_q        <= ge_d;
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    cnt_q       <= cnt_d;
    plus1_q     <= plus1_d;
    frame_div_q <= frame_div_d;
  end

  // assertions
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction left the core idle");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_frac_q <= ONE_Q16)
    else $error("fraction above one");

  a_play_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(is_playing_q) |-> $past(in_acc && func_i == FUNC_PLAY))
    else $error("playback started without a play transaction");

  a_serial_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MUL) |->
      (cnt_q != '0 && cnt_q <= CNT_BITS'(PLAY_BITS)))
    else $error("serial step count out of range");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> state_q == S_DONE)
    else $error("result dropped while output register full");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - animation frame stepper testbench
// Self-checking bench for animation_frame_stepper. A short table of opening
// transactions runs on the reset register values. Eight register settings
// follow, extremes and zero cases among them, each with a block of random
// play/stop/tick traffic. Every accepted transaction is fed to a timeline
// predictor in the bench. Every result is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import anfs_pkg::*;

  // -- timing and sizing --------------------------------------------------
  localparam int          HALF_PERIOD   = 6;     // 12 ns clock
  localparam int          RESET_CYCLES  = 10;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 85;    // about 700 transactions in all
  localparam int          HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int          HOLD_AFTER    = 150;   // results seen before the hold
  localparam int          STUCK_LIMIT   = 5000;  // cycles with no transaction
  localparam int          DRAIN_CYCLES  = 60;    // longer than the slowest transaction
  localparam int          REPORT_MAX    = 10;
  localparam logic [63:0] PRODUCT_CAP   = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_index;
    logic [FRAME_BITS-1:0] fetch_frame;
    logic [FRAC_BITS-1:0]  frac;
    logic                  playing;
  } frame_out_t;

  typedef struct {
    func_e                 func;
    logic [TIME_BITS-1:0]  delta;
    bit                    typed;   // check against the values written here
    frame_out_t            want;
  } opening_row_t;

  typedef struct {
    logic [TIME_BITS-1:0]  frame_us;
    logic [FRAME_BITS-1:0] frames;
    logic [TIME_BITS-1:0]  anim_us;
    bit                    loop;
  } reg_set_t;

  // -- DUT signals, the driven ones known from time zero -----------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [FUNC_BITS-1:0]  func_drv    = FUNC_TICK;
  logic [TIME_BITS-1:0]  delta_drv   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [FRAME_BITS-1:0] frame_index;
  logic [FRAME_BITS-1:0] fetch_frame;
  logic [FRAC_BITS-1:0]  interp_frac;
  logic                  playing;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_AW-1:0]     paddr       = '0;
  logic [APB_DW-1:0]     pwdata      = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  animation_frame_stepper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func_drv),
    .delta_us_i    (delta_drv),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .frame_index_o (frame_index),
    .fetch_frame_o (fetch_frame),
    .interp_frac_o (interp_frac),
    .playing_o     (playing),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // -- register mirror and timeline state ----------------------------------
  logic [TIME_BITS-1:0]  cfg_frame_us = FRAME_TIME_RST;
  logic [FRAME_BITS-1:0] cfg_frames   = FRAME_COUNT_RST;
  logic [TIME_BITS-1:0]  cfg_anim_us  = ANIM_TIME_RST;
  bit                    cfg_loop     = 1'b0;

  logic [63:0]           tl_play_us   = '0;   // PLAY_BITS wide in the block
  logic [FRAME_BITS-1:0] tl_frame     = 16'd1;
  bit                    tl_running   = 1'b0;
  logic [FRAC_BITS-1:0]  tl_frac      = '0;

  frame_out_t pending_frames[$];   // predicted results, oldest first

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  items_sent    = 0;
  int  stuck_cycles  = 0;
  int  phases_run    = 0;
  bit  idle_on       = 1'b1;   // random gaps/stalls allowed
  bit  hold_done     = 1'b0;

  // -- opening transactions on the reset register values ------------------
  // ft = anim = 33333, one frame, no looping. The first rows have obvious
  // results; the rest run through the end-of-animation and restart cases.
  opening_row_t opening_rows [19] = '{
    '{FUNC_TICK, 32'd0,         1'b1, '{16'd1, 16'd0, 17'd0, 1'b0}}, // stopped tick
    '{FUNC_NONE, 32'hFFFF_FFFF, 1'b1, '{16'd1, 16'd0, 17'd0, 1'b0}}, // unused code
    '{FUNC_STOP, 32'd0,         1'b1, '{16'd1, 16'd0, 17'd0, 1'b0}},
    '{FUNC_PLAY, 32'd0,         1'b1, '{16'd1, 16'd0, 17'd0, 1'b1}},
    '{FUNC_PLAY, 32'd0,         1'b1, '{16'd1, 16'd0, 17'd0, 1'b1}}, // already playing
    '{FUNC_TICK, 32'd0,         1'b1, '{16'd1, 16'd0, 17'd0, 1'b1}},
    '{FUNC_TICK, 32'd10000,     1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_TICK, 32'd20000,     1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_TICK, 32'd5000,      1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}}, // runs off the end
    '{FUNC_TICK, 32'd1,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_PLAY, 32'd0,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}}, // restart after end
    '{FUNC_TICK, 32'd33333,     1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_PLAY, 32'd0,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_TICK, 32'd33332,     1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_STOP, 32'd0,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_TICK, 32'd55555,     1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_PLAY, 32'd0,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_TICK, 32'hFFFF_FFFF, 1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}},
    '{FUNC_NONE, 32'd0,         1'b0, '{16'd0, 16'd0, 17'd0, 1'b0}}
  };

  // Register settings per phase: extremes, zero frame time / zero count,
  // looping and one-shot. Entry 6 is filled in at random at run time.
  reg_set_t phase_regs [PHASES] = '{
    '{32'd1000,      16'd10,    32'd10000,     1'b1},
    '{32'd1000,      16'd10,    32'd10000,     1'b0},
    '{32'd1,         16'hFFFF,  32'hFFFF_FFFF, 1'b1},  // frame saturation
    '{32'hFFFF_FFFF, 16'd1,     32'd1,         1'b0},
    '{32'd0,         16'd0,     32'd5000,      1'b1},  // zero time and count
    '{32'd250,       16'd7,     32'd1750,      1'b1},
    '{32'd0,         16'd0,     32'd0,         1'b0},
    '{32'd40000,     16'd3,     32'd100000,    1'b0}
  };

  function automatic logic [FRAME_BITS-1:0] clip_frame(logic [63:0] v);
    return (v > 64'(FRAME_MAX)) ? FRAME_MAX : v[FRAME_BITS-1:0];
  endfunction

  // Advance the timeline by one transaction and return the result it gives.
  function automatic frame_out_t step_timeline(func_e func, logic [TIME_BITS-1:0] d);
    logic [63:0]    ft;
    logic [63:0]    delta;
    logic [63:0]    anim;
    logic [63:0]    nxt;
    logic [63:0]    unum;
    longint signed  rem;
    longint signed  num;
    frame_out_t     r;
    delta = 64'(d);
    anim  = 64'(cfg_anim_us);
    ft    = (cfg_frame_us == '0) ? 64'd1 : 64'(cfg_frame_us);   // zero acts as one
    case (func)
      FUNC_TICK: begin
        if (tl_running) begin
          // saturating accumulate
          if (64'(PLAY_MAX) - tl_play_us < delta) tl_play_us = 64'(PLAY_MAX);
          else tl_play_us = tl_play_us + delta;
          if (tl_play_us >= anim && !cfg_loop) begin
            // park on the last frame; fraction untouched
            tl_frame   = cfg_frames;
            tl_play_us = anim + 64'd1;
            tl_running = 1'b0;
          end else if (ft >= delta) begin
            // at most one frame step, fraction towards the next frame
            if (tl_frame != '0 && ft > PRODUCT_CAP / 64'(tl_frame)) nxt = PRODUCT_CAP;
            else nxt = ft * 64'(tl_frame);
            rem = $signed(nxt) - $signed(tl_play_us);
            if (tl_play_us >= nxt) begin
              rem = rem + $signed(ft);
              if (64'(tl_frame) + 64'd1 > 64'(cfg_frames)) begin
                tl_frame   = 16'd1;
                tl_play_us = tl_play_us - nxt;
              end else begin
                tl_frame = clip_frame(64'(tl_frame) + 64'd1);
              end
            end
            num = $signed(ft) - rem;
            if (num <= 0) begin
              tl_frac = '0;
            end else begin
              unum = num;
              if (unum >= ft) tl_frac = ONE_Q16;
              else tl_frac = FRAC_BITS'((unum << 16) / ft);
            end
          end else begin
            // tick longer than a frame: recompute by floor division
            tl_frac = '0;
            if (tl_play_us > anim) begin
              tl_play_us = tl_play_us - anim;
              tl_frame   = clip_frame(tl_play_us / ft + 64'd1);
            end else begin
              tl_frame = clip_frame(tl_play_us / ft);
            end
          end
        end
      end
      FUNC_PLAY: begin
        if (!tl_running) begin
          if (tl_play_us >= anim) begin
            tl_play_us = '0;
            tl_frame   = 16'd1;
          end
          tl_running = 1'b1;
        end
      end
      FUNC_STOP: tl_running = 1'b0;
      default: ;
    endcase
    r.frame_index = tl_frame;
    r.fetch_frame = (tl_frame != '0 && tl_frame == cfg_frames) ? tl_frame - 16'd1 : tl_frame;
    r.frac        = tl_frac;
    r.playing     = tl_running;
    return r;
  endfunction

  // -- sender side ---------------------------------------------------------
  // Called at a rising edge; returns at the edge where the transaction went in.
  task automatic offer_item(func_e func, logic [TIME_BITS-1:0] d, bit typed,
                            frame_out_t typed_want);
    frame_out_t want;
    in_valid  <= 1'b1;
    func_drv  <= func;
    delta_drv <= d;
    do @(posedge clk_i); while (in_stall);
    want = step_timeline(func, d);
    if (typed) want = typed_want;
    pending_frames.push_back(want);
    items_sent++;
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // APB write with a setup and an access phase; the register takes the value
  // on the access edge. An idle bus follows so back-to-back writes start fresh.
  task automatic reg_write(reg_idx_e idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Tick lengths biased around the frame time so both the in-frame and the
  // floor-division paths are exercised, plus the field extremes.
  function automatic logic [TIME_BITS-1:0] pick_delta();
    logic [TIME_BITS-1:0] ft;
    int unsigned          sel;
    ft  = (cfg_frame_us == '0) ? 32'd1 : cfg_frame_us;
    sel = $urandom_range(0, 99);
    if (sel < 45)      return $urandom_range(0, ft);
    else if (sel < 55) return $urandom_range(0, (ft >> 3) + 1);
    else if (sel < 62) return ft;
    else if (sel < 74) return (ft > 32'hFFFF_FC00) ? 32'hFFFF_FFFF : ft + $urandom_range(1, 1000);
    else if (sel < 86) return $urandom();
    else if (sel < 92) return 32'hFFFF_FFFF;
    else               return 32'd0;
  endfunction

  // Mostly ticks while running; when stopped, usually restart playback so
  // that the run spends its time deep in the timeline.
  function automatic func_e pick_func();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!tl_running) return (sel < 60) ? FUNC_PLAY : (sel < 92) ? FUNC_TICK :
                            (sel < 96) ? FUNC_STOP : FUNC_NONE;
    if (sel < 87)      return FUNC_TICK;
    else if (sel < 92) return FUNC_STOP;
    else if (sel < 97) return FUNC_PLAY;
    else               return FUNC_NONE;
  endfunction

  initial begin : stimulus
    reg_set_t rs;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      maybe_gap();
      offer_item(opening_rows[i].func, opening_rows[i].delta, opening_rows[i].typed,
                 opening_rows[i].want);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only once every outstanding result is back
      wait_drained();
      rs = phase_regs[ph];
      if (ph == 6) begin
        rs.frame_us = $urandom_range(1, 100000);
        rs.frames   = FRAME_BITS'($urandom_range(1, 40));
        rs.anim_us  = $urandom_range(rs.frame_us, rs.frame_us * rs.frames);
        rs.loop     = 1'($urandom_range(0, 1));
      end
      reg_write(REG_FRAME_TIME,  rs.frame_us);
      reg_write(REG_FRAME_COUNT, APB_DW'(rs.frames));
      reg_write(REG_ANIM_TIME,   rs.anim_us);
      reg_write(REG_REPEAT_ON,   APB_DW'(rs.loop));
      cfg_frame_us = rs.frame_us;
      cfg_frames   = rs.frames;
      cfg_anim_us  = rs.anim_us;
      cfg_loop     = rs.loop;
      phases_run++;
      // every third phase and the closing one run without idling
      idle_on = (ph % 3 != 2) && (ph != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        maybe_gap();
        offer_item(pick_func(), pick_delta(), 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_frames.size() != 0) mismatches++;
    $display("Ran %0d transactions over %0d register settings plus reset values;",
             items_sent, phases_run);
    $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // -- receiver side: checking, random stalls and one long hold-off ---------
  task automatic check_result();
    frame_out_t got;
    frame_out_t want;
    got.frame_index = frame_index;
    got.fetch_frame = fetch_frame;
    got.frac        = interp_frac;
    got.playing     = playing;
    results_seen++;
    if (pending_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: result with nothing outstanding: frame %0d fetch %0d frac %0d play %0b",
                 $realtime, got.frame_index, got.fetch_frame, got.frac, got.playing);
    end else begin
      want = pending_frames.pop_front();
      if (got.frame_index !== want.frame_index || got.fetch_frame !== want.fetch_frame ||
          got.frac !== want.frac || got.playing !== want.playing) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: #%0d exp/act frame %0d/%0d fetch %0d/%0d frac %0d/%0d play %0b/%0b",
                   $realtime, results_seen, want.frame_index, got.frame_index,
                   want.fetch_frame, got.fetch_frame, want.frac, got.frac,
                   want.playing, got.playing);
      end
    end
  endtask

  initial begin : result_side
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) check_result();
      // long hold-off: the sender keeps offering so the block backs up
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // -- watchdog: too long with no transaction on either channel -----------
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: %0d cycles without a transaction, %0d results outstanding",
               STUCK_LIMIT, pending_frames.size());
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
sv/anfs_pkg.sv
sv/animation_frame_stepper.sv
verif/tb.sv
